/* rtl/core/ico_learning_neuron_macros.svh */
// ----------------------------------------------------------------------------
// ico_learning_neuron_macros.svh
// Assertion macros for the learning neuron core; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ICO_LEARNING_NEURON_MACROS_SVH
`define ICO_LEARNING_NEURON_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset
`define ICOL_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("icol assertion failed");

// Check that a condition holds in the cycle after a trigger
`define ICOL_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("icol assertion failed");

`else

`define ICOL_ASSERT(label, clk, rst_n, cond)
`define ICOL_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

/* rtl/core/icol_pkg.sv */
// ----------------------------------------------------------------------------
// icol_pkg
// Shared types and constants of the input correlation learning neuron.
// ----------------------------------------------------------------------------
`default_nettype none

package icol_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 32;
    localparam int DOT_W      = SAMPLE_W + WEIGHT_W;   // one predictor * weight
    localparam int DOT_SUM_W  = DOT_W + 3;             // sum over up to eight lanes
    localparam int SQ_W       = 64;
    localparam int SQ_SUM_W   = SQ_W + 3;
    localparam int MAX_INPUTS = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_MODE    = 8'd1;

    // Q16.16 constants
    localparam logic signed [WEIGHT_W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [WEIGHT_W-1:0] W_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [WEIGHT_W-1:0] W_MIN   = 32'sh8000_0000;

    // Lane step enables, driven by the sequencer
    typedef struct packed {
        logic load;   // capture predictor
        logic mul;    // predictor * weight
        logic prod;   // rate_err * predictor
        logic upd;    // weight update
        logic sq;     // squared distance from 1.0
    } t_lane_ctrl;

    // Merge step enables
    typedef struct packed {
        logic dot_en;
        logic sq_en;
    } t_merge_ctrl;

endpackage

`default_nettype wire

/* rtl/core/icol_lane.sv */
// ----------------------------------------------------------------------------
// icol_lane
// One weight lane: holds a Q16.16 weight, forms its dot term, its update and
// its squared distance from 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module icol_lane (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire icol_pkg::t_lane_ctrl                  i_ctrl,
    input  wire logic signed [icol_pkg::SAMPLE_W-1:0]  i_pred,
    input  wire logic signed [icol_pkg::WEIGHT_W-1:0]  i_rate_err,
    output logic signed [icol_pkg::DOT_W-1:0]          o_dot,
    output logic        [icol_pkg::SQ_W-1:0]           o_sq
);

    logic signed [icol_pkg::SAMPLE_W-1:0] r_pred;
    logic signed [icol_pkg::WEIGHT_W-1:0] r_weight;
    logic signed [icol_pkg::WEIGHT_W-1:0] n_weight;
    logic signed [icol_pkg::DOT_W-1:0]    r_dot;
    logic signed [icol_pkg::DOT_W-1:0]    r_prod;
    logic        [icol_pkg::SQ_W-1:0]     r_sq;

    logic signed [icol_pkg::DOT_W-1:0]    w_dot;
    logic signed [icol_pkg::DOT_W-1:0]    w_prod;
    logic signed [23:0]                   w_delta;
    logic signed [icol_pkg::WEIGHT_W:0]   w_sum;
    logic signed [icol_pkg::WEIGHT_W:0]   w_diff;
    logic        [icol_pkg::WEIGHT_W-1:0] w_mag;
    logic        [icol_pkg::SQ_W-1:0]     w_sq;

    // Products of the lane
    assign w_dot  = r_pred * r_weight;
    assign w_prod = i_rate_err * r_pred;

    // Floor the 40 fraction bit product to Q16.16 and saturate the new weight
    assign w_delta = r_prod[icol_pkg::DOT_W-1:24];
    assign w_sum   = (icol_pkg::WEIGHT_W+1)'(r_weight) + (icol_pkg::WEIGHT_W+1)'(w_delta);

    always_comb begin
        if (!w_sum[icol_pkg::WEIGHT_W] && w_sum[icol_pkg::WEIGHT_W-1]) begin
            n_weight = icol_pkg::W_MAX;
        end else if (w_sum[icol_pkg::WEIGHT_W] && !w_sum[icol_pkg::WEIGHT_W-1]) begin
            n_weight = icol_pkg::W_MIN;
        end else begin
            n_weight = w_sum[icol_pkg::WEIGHT_W-1:0];
        end
    end

    // Magnitude of the distance from 1.0, then its square
    assign w_diff = (icol_pkg::WEIGHT_W+1)'(r_weight)
                  - (icol_pkg::WEIGHT_W+1)'(icol_pkg::ONE_Q16);
    assign w_mag  = w_diff[icol_pkg::WEIGHT_W] ? icol_pkg::WEIGHT_W'(-w_diff)
                                               : w_diff[icol_pkg::WEIGHT_W-1:0];
    assign w_sq   = icol_pkg::SQ_W'(w_mag) * icol_pkg::SQ_W'(w_mag);

    // Hold the weight; reset to 1.0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= icol_pkg::ONE_Q16;
        end else if (i_ctrl.upd) begin
            r_weight <= n_weight;
        end
    end

    // Advance the working registers step by step
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_pred <= i_pred;
        end
        if (i_ctrl.mul) begin
            r_dot <= w_dot;
        end
        if (i_ctrl.prod) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.sq) begin
            r_sq <= w_sq;
        end
    end

    assign o_dot = r_dot;
    assign o_sq  = r_sq;

endmodule

`default_nettype wire

/* rtl/core/icol_merge.sv */
// ----------------------------------------------------------------------------
// icol_merge
// Combines the lanes: saturated neuron output and the sum of squared
// weight distances with its overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module icol_merge #(
    parameter int N = 8
) (
    input  wire logic                                 i_clk,
    input  wire icol_pkg::t_merge_ctrl                i_ctrl,
    input  wire logic signed [icol_pkg::DOT_W-1:0]    i_dot [N],
    input  wire logic        [icol_pkg::SQ_W-1:0]     i_sq  [N],
    output logic signed [icol_pkg::WEIGHT_W-1:0]      o_neuron,
    output logic        [icol_pkg::SQ_W-1:0]          o_sq_sum,
    output logic                                      o_sq_ovf
);

    logic signed [icol_pkg::DOT_SUM_W-1:0] w_dot_sum;
    logic signed [icol_pkg::DOT_SUM_W-1:0] w_dot_q16;
    logic        [icol_pkg::SQ_SUM_W-1:0]  w_sq_sum;
    logic signed [icol_pkg::WEIGHT_W-1:0]  w_neuron;
    logic                                  w_pos_ovf;
    logic                                  w_neg_ovf;

    logic signed [icol_pkg::WEIGHT_W-1:0]  r_neuron;
    logic        [icol_pkg::SQ_W-1:0]      r_sq_sum;
    logic                                  r_sq_ovf;

    // Sum the lane terms
    always_comb begin
        w_dot_sum = '0;
        w_sq_sum  = '0;
        for (int k = 0; k < N; k++) begin
            w_dot_sum = w_dot_sum + icol_pkg::DOT_SUM_W'(i_dot[k]);
            w_sq_sum  = w_sq_sum + icol_pkg::SQ_SUM_W'(i_sq[k]);
        end
    end

    // Floor to Q16.16 and saturate to 32 bits
    assign w_dot_q16 = w_dot_sum >>> 12;
    assign w_pos_ovf = !w_dot_q16[icol_pkg::DOT_SUM_W-1]
                     && (|w_dot_q16[icol_pkg::DOT_SUM_W-2:icol_pkg::WEIGHT_W-1]);
    assign w_neg_ovf = w_dot_q16[icol_pkg::DOT_SUM_W-1]
                     && !(&w_dot_q16[icol_pkg::DOT_SUM_W-2:icol_pkg::WEIGHT_W-1]);

    always_comb begin
        if (w_pos_ovf) begin
            w_neuron = icol_pkg::W_MAX;
        end else if (w_neg_ovf) begin
            w_neuron = icol_pkg::W_MIN;
        end else begin
            w_neuron = w_dot_q16[icol_pkg::WEIGHT_W-1:0];
        end
    end

    // Hold merged results until the next item
    always_ff @(posedge i_clk) begin
        if (i_ctrl.dot_en) begin
            r_neuron <= w_neuron;
        end
        if (i_ctrl.sq_en) begin
            r_sq_sum <= w_sq_sum[icol_pkg::SQ_W-1:0];
            r_sq_ovf <= |w_sq_sum[icol_pkg::SQ_SUM_W-1:icol_pkg::SQ_W];
        end
    end

    assign o_neuron = r_neuron;
    assign o_sq_sum = r_sq_sum;
    assign o_sq_ovf = r_sq_ovf;

endmodule

`default_nettype wire

/* rtl/core/icol_isqrt.sv */
// ----------------------------------------------------------------------------
// icol_isqrt
// Iterative floored integer square root of a 64-bit value, one result bit
// per cycle, saturating to all ones on overflow.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ico_learning_neuron_macros.svh"

module icol_isqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [icol_pkg::SQ_W-1:0]     i_value,
    input  wire logic                          i_ovf,
    output logic                               o_done,
    output logic [icol_pkg::WEIGHT_W-1:0]      o_root
);

    localparam logic [icol_pkg::SQ_W-1:0] BIT_TOP = 64'h4000_0000_0000_0000;

    logic                          r_busy;
    logic                          r_done;
    logic [icol_pkg::SQ_W-1:0]     r_rem;
    logic [icol_pkg::SQ_W-1:0]     r_res;
    logic [icol_pkg::SQ_W-1:0]     r_bit;
    logic                          r_ovf;

    logic [icol_pkg::SQ_W-1:0]     w_trial;
    logic                          w_fits;

    assign w_trial = r_res + r_bit;
    assign w_fits  = (r_rem >= w_trial);

    // Control: busy for one pass of 32 steps, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    // One restoring step per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
            r_res <= '0;
            r_bit <= BIT_TOP;
            r_ovf <= i_ovf;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= r_rem - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_ovf ? '1 : r_res[icol_pkg::WEIGHT_W-1:0];

    `ICOL_ASSERT(a_no_restart, i_clk, i_rst_n, !(i_start && r_busy))
    `ICOL_ASSERT(a_bit_onehot, i_clk, i_rst_n, !r_busy || $onehot(r_bit))

endmodule

`default_nettype wire

/* rtl/core/ico_learning_neuron.sv */
// ----------------------------------------------------------------------------
// ico_learning_neuron
// Adaptive linear neuron with input correlation learning: one weight lane
// per predictor, a merge stage and an iterative square root.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 word
//  input     in         i_in_valid / o_in_stall   predictors 0..7, error sample
//  output    out        o_out_valid / i_out_stall neuron output, weight distance
//  config    in         i_cfg_valid / o_cfg_ready register index, write data
//
//  From acceptance, an item passes through six lane and merge steps, 32 square
//  root steps (one root bit per cycle) and a hand-off through S_DONE into the
//  output register. No new item is taken until the last one has left S_DONE.
//  The next item can be taken in the cycle after the result enters the output
//  register, even while that result is still stalled.
//  Reset (synchronous, active low) sets every weight to 1.0 and clears the
//  previous error and both registers; there is no clearing pass.
//  Configuration writes are always taken; they are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ico_learning_neuron_macros.svh"

module ico_learning_neuron #(
    parameter int NUM_INPUTS = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // Input channel
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_stall,
    input  wire logic signed [icol_pkg::SAMPLE_W-1:0]    i_predictor_0,
    input  wire logic signed [icol_pkg::SAMPLE_W-1:0]    i_predictor_1,
    input  wire logic signed [icol_pkg::SAMPLE_W-1:0]    i_predictor_2,
    input  wire logic signed [icol_pkg::SAMPLE_W-1:0]    i_predictor_3,
    input  wire logic signed [icol_pkg::SAMPLE_W-1:0]    i_predictor_4,
    input  wire logic signed [icol_pkg::SAMPLE_W-1:0]    i_predictor_5,
    input  wire logic signed [icol_pkg::SAMPLE_W-1:0]    i_predictor_6,
    input  wire logic signed [icol_pkg::SAMPLE_W-1:0]    i_predictor_7,
    input  wire logic signed [icol_pkg::SAMPLE_W-1:0]    i_error_sample,
    // Output channel
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_stall,
    output logic signed [icol_pkg::WEIGHT_W-1:0]         o_neuron_output,
    output logic        [icol_pkg::WEIGHT_W-1:0]         o_weight_distance,
    // Configuration channel
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [icol_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [icol_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_PROD,
        S_UPD,
        S_SQ,
        S_SUM,
        S_START,
        S_ROOT,
        S_DONE
    } t_state;

    t_state                                r_state;
    logic [15:0]                           r_learning_rate;
    logic                                  r_error_mode;
    logic signed [icol_pkg::SAMPLE_W-1:0]  r_prev_err;
    logic signed [icol_pkg::SAMPLE_W-1:0]  r_eff_err;
    logic signed [icol_pkg::WEIGHT_W-1:0]  r_rate_err;
    logic                                  r_out_valid;
    logic signed [icol_pkg::WEIGHT_W-1:0]  r_neuron;
    logic        [icol_pkg::WEIGHT_W-1:0]  r_dist;

    logic                                  w_in_acc;
    logic                                  w_out_free;
    logic                                  w_done_wait;
    logic signed [icol_pkg::SAMPLE_W:0]    w_err_diff;
    logic signed [icol_pkg::SAMPLE_W-1:0]  n_eff_err;
    logic signed [icol_pkg::SAMPLE_W:0]    w_rate_s;
    logic signed [icol_pkg::WEIGHT_W:0]    w_rate_err;
    logic signed [icol_pkg::SAMPLE_W-1:0]  w_pred [icol_pkg::MAX_INPUTS];

    icol_pkg::t_lane_ctrl                  w_lane_ctrl;
    icol_pkg::t_merge_ctrl                 w_merge_ctrl;
    logic signed [icol_pkg::DOT_W-1:0]     w_dot [NUM_INPUTS];
    logic        [icol_pkg::SQ_W-1:0]      w_sq  [NUM_INPUTS];
    logic signed [icol_pkg::WEIGHT_W-1:0]  w_neuron;
    logic        [icol_pkg::SQ_W-1:0]      w_sq_sum;
    logic                                  w_sq_ovf;
    logic                                  w_root_done;
    logic        [icol_pkg::WEIGHT_W-1:0]  w_root;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_done_wait = (r_state == S_DONE) && !w_out_free;

    // Gather the predictor ports
    assign w_pred[0] = i_predictor_0;
    assign w_pred[1] = i_predictor_1;
    assign w_pred[2] = i_predictor_2;
    assign w_pred[3] = i_predictor_3;
    assign w_pred[4] = i_predictor_4;
    assign w_pred[5] = i_predictor_5;
    assign w_pred[6] = i_predictor_6;
    assign w_pred[7] = i_predictor_7;

    // Effective error: raw, or halved difference of successive errors
    assign w_err_diff = (icol_pkg::SAMPLE_W+1)'(r_prev_err)
                      - (icol_pkg::SAMPLE_W+1)'(i_error_sample);
    assign n_eff_err  = r_error_mode ? w_err_diff[icol_pkg::SAMPLE_W:1] : i_error_sample;

    // Learning rate times effective error; magnitude stays below 2^31
    assign w_rate_s   = $signed({1'b0, r_learning_rate});
    assign w_rate_err = w_rate_s * r_eff_err;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learning_rate <= '0;
            r_error_mode    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                icol_pkg::CFG_LEARNING_RATE: r_learning_rate <= i_cfg_data;
                icol_pkg::CFG_ERROR_MODE:    r_error_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer, error tracking and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drain the output register; a waiting word refills it in S_DONE
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_eff_err <= n_eff_err;
                        if (r_error_mode) begin
                            r_prev_err <= i_error_sample;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rate_err <= w_rate_err[icol_pkg::WEIGHT_W-1:0];
                    r_state    <= S_PROD;
                end
                S_PROD:  r_state <= S_UPD;
                S_UPD:   r_state <= S_SQ;
                S_SQ:    r_state <= S_SUM;
                S_SUM:   r_state <= S_START;
                S_START: r_state <= S_ROOT;
                S_ROOT: begin
                    if (w_root_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_neuron    <= w_neuron;
                        r_dist      <= w_root;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Step enables for lanes and merge
    assign w_lane_ctrl.load    = w_in_acc;
    assign w_lane_ctrl.mul     = (r_state == S_MUL);
    assign w_lane_ctrl.prod    = (r_state == S_PROD);
    assign w_lane_ctrl.upd     = (r_state == S_UPD);
    assign w_lane_ctrl.sq      = (r_state == S_SQ);
    assign w_merge_ctrl.dot_en = (r_state == S_PROD);
    assign w_merge_ctrl.sq_en  = (r_state == S_SUM);

    // Weight lanes
    for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_lane
        icol_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_lane_ctrl),
            .i_pred     (w_pred[g]),
            .i_rate_err (r_rate_err),
            .o_dot      (w_dot[g]),
            .o_sq       (w_sq[g])
        );
    end

    icol_merge #(
        .N (NUM_INPUTS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_ctrl   (w_merge_ctrl),
        .i_dot    (w_dot),
        .i_sq     (w_sq),
        .o_neuron (w_neuron),
        .o_sq_sum (w_sq_sum),
        .o_sq_ovf (w_sq_ovf)
    );

    icol_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_value (w_sq_sum),
        .i_ovf   (w_sq_ovf),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    assign o_out_valid       = r_out_valid;
    assign o_neuron_output   = r_neuron;
    assign o_weight_distance = r_dist;

    `ICOL_ASSERT(a_root_done_in_wait, i_clk, i_rst_n, !w_root_done || r_state == S_ROOT)
    `ICOL_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_in_acc, r_state == S_MUL)
    `ICOL_ASSERT_NEXT(a_done_waits, i_clk, i_rst_n, w_done_wait, r_state == S_DONE && r_out_valid)

endmodule

`default_nettype wire
